// ----- rtl/sktb_pkg.sv -----
// Shared widths, command and status codes for the sorted keyed balance table.
`timescale 1ns / 1ps
package sktb_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned AMT_W    = 32;
  localparam int unsigned BAL_W    = 48;
  localparam int unsigned TOT_W    = 56;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_QUERY2 = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [BAL_W-1:0] bal;
  } entry_t;

endpackage

// ----- rtl/sorted_keyed_balance_table.sv -----
// Top level: sorted key/balance table kept in one RAM, with sequencer and divider.
`timescale 1ns / 1ps
// Channel   Ports                                    Handshake
// request   cmd_i, key_i, amount_i                   taken when start & !busy
// result    status_o, entry_key_o, entry_balance_o,  one cycle, marked by done_o
//           entry_count_o, average_o
//
// Add and remove search the sorted entries linearly up to the slot, then shift
// the entries past it one slot at a time through the single RAM port pair.
// A query on a non-empty table takes its average from the bit-serial 56-step divider.
// Reset clears count, total and the sequencer; RAM contents are not cleared.
// The result receiver cannot stall: done_o marks a result for exactly one cycle.
module sorted_keyed_balance_table #(
  parameter int unsigned CAPACITY = sktb_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sktb_pkg::CMD_W-1:0]    cmd_i,
  input  logic [sktb_pkg::KEY_W-1:0]    key_i,
  input  logic signed [sktb_pkg::AMT_W-1:0] amount_i,
  output logic                          done_o,
  output logic [sktb_pkg::STATUS_W-1:0] status_o,
  output logic [sktb_pkg::KEY_W-1:0]    entry_key_o,
  output logic signed [sktb_pkg::BAL_W-1:0] entry_balance_o,
  output logic [sktb_pkg::COUNT_W-1:0]  entry_count_o,
  output logic signed [sktb_pkg::BAL_W-1:0] average_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned KW   = sktb_pkg::KEY_W;
  localparam int unsigned BW   = sktb_pkg::BAL_W;
  localparam int unsigned TW   = sktb_pkg::TOT_W;
  localparam int unsigned EW   = KW + BW;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_SHUP, S_SHDN, S_DIV
  } state_e;

  state_e                    state_q;
  sktb_pkg::cmd_e            cmd_q;
  logic [KW-1:0]             key_q;
  logic [sktb_pkg::AMT_W-1:0] amt_q;
  logic [CW-1:0]             count_q;
  logic [TW-1:0]             total_q;
  logic [CW-1:0]             ptr_q;
  logic [CW-1:0]             pos_q;
  logic [CW-1:0]             wa_q;
  logic                      pend_q;
  logic                      hit_q;
  logic [BW-1:0]             old_q;
  logic                      tot_neg_q;

  logic                      done_q;
  sktb_pkg::status_e         status_q;
  logic [KW-1:0]             rkey_q;
  logic [BW-1:0]             rbal_q;
  logic [CW-1:0]             rcnt_q;
  logic [BW-1:0]             ravg_q;

  // RAM ports
  logic                      we;
  logic [AW-1:0]             waddr;
  sktb_pkg::entry_t          wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic [EW-1:0]             rdata_raw;
  sktb_pkg::entry_t          rdata;

  // divider
  logic                      div_start;
  logic                      div_done;
  logic [TW-1:0]             div_quo;
  logic [TW-1:0]             tot_mag;

  // arithmetic
  logic [BW-1:0]             amt_ext;
  logic [BW:0]               sum49;
  logic [BW-1:0]             nb;
  logic [BW:0]               delta;
  logic [TW:0]               tot_upd;
  logic [TW:0]               tot_ins;
  logic [TW:0]               tot_rem;
  logic [BW-1:0]             avg;
  logic [CW+sktb_pkg::COUNT_W-1:0] cnt_ext;

  localparam logic [BW-1:0]  MAX48 = {1'b0, {(BW-1){1'b1}}};
  localparam logic [BW-1:0]  MIN48 = {1'b1, {(BW-1){1'b0}}};
  localparam logic [TW-1:0]  MAX56 = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0]  MIN56 = {1'b1, {(TW-1){1'b0}}};

  function automatic logic [TW-1:0] sat_tot(input logic [TW:0] v);
    if (v[TW] != v[TW-1]) begin
      return v[TW] ? MIN56 : MAX56;
    end
    return v[TW-1:0];
  endfunction

  assign rdata   = sktb_pkg::entry_t'(rdata_raw);
  assign amt_ext = {{(BW-sktb_pkg::AMT_W){amt_q[sktb_pkg::AMT_W-1]}}, amt_q};

  // credit an existing entry: 49-bit sum, clamp to 48 bits
  assign sum49   = {old_q[BW-1], old_q} + {amt_ext[BW-1], amt_ext};
  assign nb      = (sum49[BW] != sum49[BW-1]) ? (sum49[BW] ? MIN48 : MAX48) : sum49[BW-1:0];
  assign delta   = {nb[BW-1], nb} - {old_q[BW-1], old_q};
  assign tot_upd = {total_q[TW-1], total_q} + {{(TW-BW){delta[BW]}}, delta};
  assign tot_ins = {total_q[TW-1], total_q} + {{(TW-BW+1){amt_ext[BW-1]}}, amt_ext};
  assign tot_rem = {total_q[TW-1], total_q} - {{(TW-BW+1){old_q[BW-1]}}, old_q};

  assign tot_mag = total_q[TW-1] ? (~total_q + 1'b1) : total_q;

  // sign and clamp the quotient magnitude to 48 bits
  always_comb begin
    if (tot_neg_q) begin
      if (div_quo > {{(TW-BW){1'b0}}, MIN48}) begin
        avg = MIN48;
      end else begin
        avg = ~div_quo[BW-1:0] + 1'b1;
      end
    end else if (div_quo > {{(TW-BW){1'b0}}, MAX48}) begin
      avg = MAX48;
    end else begin
      avg = div_quo[BW-1:0];
    end
  end

  // RAM access per state
  always_comb begin
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata;
    div_start = 1'b0;
    unique case (state_q)
      S_SEARCH: begin
        re    = (ptr_q < count_q);
        raddr = ptr_q[AW-1:0];
      end
      S_DECIDE: begin
        // credit in place on a hit
        if (cmd_q == sktb_pkg::CMD_ADD && hit_q) begin
          we        = 1'b1;
          waddr     = pos_q[AW-1:0];
          wdata.key = key_q;
          wdata.bal = nb;
        end
        div_start = (cmd_q == sktb_pkg::CMD_QUERY || cmd_q == sktb_pkg::CMD_QUERY2)
                    && (count_q != '0);
      end
      S_SHUP: begin
        // move entries up one slot, top first, then drop the new entry in
        re    = (ptr_q != pos_q);
        raddr = ptr_q[AW-1:0] - 1'b1;
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q[AW-1:0];
        end else if (ptr_q == pos_q) begin
          we        = 1'b1;
          waddr     = pos_q[AW-1:0];
          wdata.key = key_q;
          wdata.bal = amt_ext;
        end
      end
      S_SHDN: begin
        // pull entries down one slot over the removed one
        re    = (ptr_q < count_q);
        raddr = ptr_q[AW-1:0];
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      done_q   <= 1'b0;
      pend_q   <= 1'b0;
      status_q <= sktb_pkg::ST_ADDED;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= sktb_pkg::cmd_e'(cmd_i);
            key_q  <= key_i;
            amt_q  <= amount_i;
            ptr_q  <= '0;
            pend_q <= 1'b0;
            hit_q  <= 1'b0;
            if (cmd_i == sktb_pkg::CMD_QUERY || cmd_i == sktb_pkg::CMD_QUERY2) begin
              state_q <= S_DECIDE;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (pend_q && rdata.key >= key_q) begin
            pos_q   <= ptr_q - 1'b1;
            hit_q   <= (rdata.key == key_q);
            old_q   <= rdata.bal;
            pend_q  <= 1'b0;
            state_q <= S_DECIDE;
          end else if (ptr_q >= count_q) begin
            pos_q   <= count_q;
            hit_q   <= 1'b0;
            pend_q  <= 1'b0;
            state_q <= S_DECIDE;
          end else begin
            ptr_q  <= ptr_q + 1'b1;
            pend_q <= 1'b1;
          end
        end
        S_DECIDE: begin
          rkey_q <= key_q;
          rbal_q <= '0;
          ravg_q <= '0;
          rcnt_q <= count_q;
          priority if (cmd_q == sktb_pkg::CMD_ADD) begin
            if (hit_q) begin
              total_q  <= sat_tot(tot_upd);
              rbal_q   <= nb;
              status_q <= sktb_pkg::ST_UPDATED;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else if (count_q == CW'(CAPACITY)) begin
              status_q <= sktb_pkg::ST_FULL;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              ptr_q   <= count_q;
              state_q <= S_SHUP;
            end
          end else if (cmd_q == sktb_pkg::CMD_REMOVE) begin
            if (count_q == '0) begin
              status_q <= sktb_pkg::ST_EMPTY;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else if (!hit_q) begin
              status_q <= sktb_pkg::ST_NOT_FOUND;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              ptr_q   <= pos_q + 1'b1;
              state_q <= S_SHDN;
            end
          end else begin
            rkey_q <= '0;
            if (count_q == '0) begin
              status_q <= sktb_pkg::ST_EMPTY;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              tot_neg_q <= total_q[TW-1];
              state_q   <= S_DIV;
            end
          end
        end
        S_SHUP: begin
          if (ptr_q != pos_q) begin
            wa_q   <= ptr_q;
            ptr_q  <= ptr_q - 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              count_q  <= count_q + 1'b1;
              total_q  <= sat_tot(tot_ins);
              rbal_q   <= amt_ext;
              rcnt_q   <= count_q + 1'b1;
              status_q <= sktb_pkg::ST_ADDED;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_SHDN: begin
          if (ptr_q < count_q) begin
            wa_q   <= ptr_q - 1'b1;
            ptr_q  <= ptr_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              count_q  <= count_q - 1'b1;
              total_q  <= sat_tot(tot_rem);
              rbal_q   <= old_q;
              rcnt_q   <= count_q - 1'b1;
              status_q <= sktb_pkg::ST_REMOVED;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            ravg_q   <= avg;
            status_q <= sktb_pkg::ST_ADDED;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  sktb_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  sktb_div #(
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tot_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cnt_ext         = {{sktb_pkg::COUNT_W{1'b0}}, rcnt_q};
  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign entry_key_o     = rkey_q;
  assign entry_balance_o = rbal_q;
  assign entry_count_o   = cnt_ext[sktb_pkg::COUNT_W-1:0];
  assign average_o       = ravg_q;

endmodule

// ----- rtl/sktb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sktb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sktb_div.sv -----
// Restoring divider: unsigned total magnitude over entry count, one bit a cycle.
`timescale 1ns / 1ps
module sktb_div #(
  parameter int unsigned CW = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sktb_pkg::TOT_W-1:0] dividend_i,
  input  logic [CW-1:0]              divisor_i,
  output logic                       done_o,
  output logic [sktb_pkg::TOT_W-1:0] quotient_o
);

  localparam int unsigned NW = $clog2(sktb_pkg::TOT_W + 1);

  logic [CW:0]                 rem_q;
  logic [sktb_pkg::TOT_W-1:0]  quo_q;
  logic [CW-1:0]               dsr_q;
  logic [NW-1:0]               cnt_q;
  logic                        run_q;
  logic                        done_q;
  logic [CW+1:0]               trial;
  logic [CW:0]                 shifted;

  assign shifted = {rem_q[CW-1:0], quo_q[sktb_pkg::TOT_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= NW'(sktb_pkg::TOT_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      if (!trial[CW+1]) begin
        rem_q <= trial[CW:0];
        quo_q <= {quo_q[sktb_pkg::TOT_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[sktb_pkg::TOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/sktb_chk.sv -----
// Port-level checker for the sorted keyed balance table, bound to the top level.
`timescale 1ns / 1ps
module sktb_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [sktb_pkg::STATUS_W-1:0] status_o,
  input logic [sktb_pkg::BAL_W-1:0]    average_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= sktb_pkg::ST_EMPTY)
    else $error("status code out of range");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != sktb_pkg::ST_ADDED |-> average_o == '0)
    else $error("average set on a non-query result");

endmodule

bind sorted_keyed_balance_table sktb_chk u_sktb_chk (.*);
